FILE: rtl/core/apq_pkg.sv
// Shared types and codes for the array min-priority queue.
`timescale 1ns / 1ps
`default_nettype none

package apq_pkg;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DELETE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // command word
  typedef struct packed {
    func_t              func;
    logic signed [31:0] item_value;
    logic signed [31:0] item_prio;
  } cmd_t;

  // result word
  typedef struct packed {
    status_t            status;
    logic signed [31:0] removed_value;
    logic signed [31:0] removed_prio;
    logic        [7:0]  fill_count;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/apq_min_unit.sv
// Compare unit: tracks the running minimum priority during a scan.
`timescale 1ns / 1ps
`default_nettype none

module apq_min_unit
  #(
    parameter int AW = 7,
    parameter int VW = 32,
    parameter int PW = 32
  )
  (
    input  wire logic          clk,
    input  wire logic          cand_vld,
    input  wire logic          cand_first,
    input  wire logic [AW-1:0] cand_idx,
    input  wire logic [VW-1:0] cand_value,
    input  wire logic [PW-1:0] cand_prio,
    output logic      [AW-1:0] best_idx,
    output logic      [VW-1:0] best_value,
    output logic      [PW-1:0] best_prio
  );

  logic take;

  // strict less-than keeps the earliest entry on ties
  assign take = cand_vld && (cand_first || ($signed(cand_prio) < $signed(best_prio)));

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx   <= cand_idx;
      best_value <= cand_value;
      best_prio  <= cand_prio;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/array_min_priority_queue.sv
// Top level of the unsorted-array min-priority queue with a sequenced scan/shift delete.
// Insert: result strobed the cycle after acceptance; busy stays low.
// Delete: a scan reads every stored entry in order to find the minimum m, then a shift reads
//   the entries above m and writes each one address down (none move if m is last); done
//   strobes once the shift has drained, with one store read per cycle throughout.
// Empty delete or full insert: result the cycle after acceptance; results are never stalled.
// Synchronous active-high reset empties the queue; store contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module array_min_priority_queue
  import apq_pkg::*;
  #(
    parameter int DEPTH       = 128,
    parameter int VALUE_WIDTH = 32,
    parameter int PRIO_WIDTH  = 32
  )
  (
    input  wire logic clk,
    input  wire logic rst,
    input  wire logic start,
    output logic      busy,
    input  wire cmd_t cmd,
    output logic      done,
    output result_t   result
  );

  localparam int AW = $clog2(DEPTH);       // store address bits
  localparam int CW = $clog2(DEPTH + 1);   // count bits, holds DEPTH itself
  localparam int EW = VALUE_WIDTH + PRIO_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t state;

  logic [CW-1:0] count;   // stored entries
  logic [CW-1:0] ptr;     // next store address to read

  // store: one write, one registered read per cycle
  logic [EW-1:0] mem [DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [EW-1:0] rd_data;
  logic          rd_vld;   // rd_data holds a fresh word
  logic [AW-1:0] rd_idx;   // store index of rd_data

  logic accept;
  logic drained;

  logic [AW-1:0]          best_idx;
  logic [VALUE_WIDTH-1:0] best_value;
  logic [PRIO_WIDTH-1:0]  best_prio;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign rd_en   = (state == S_SCAN || state == S_SHIFT) && (ptr < count);
  assign drained = !rd_vld && (ptr >= count);

  // write port: append on insert, move down by one during shift
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = {VALUE_WIDTH'($unsigned(cmd.item_value)),
               PRIO_WIDTH'($unsigned(cmd.item_prio))};
    if (accept && cmd.func == FUNC_INSERT && count < CW'(DEPTH)) begin
      wr_en = 1'b1;
    end else if (state == S_SHIFT && rd_vld) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx - 1'b1;
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[ptr[AW-1:0]];
      rd_idx  <= ptr[AW-1:0];
    end
  end

  apq_min_unit #(
    .AW (AW),
    .VW (VALUE_WIDTH),
    .PW (PRIO_WIDTH)
  ) u_min (
    .clk        (clk),
    .cand_vld   (state == S_SCAN && rd_vld),
    .cand_first (rd_idx == '0),
    .cand_idx   (rd_idx),
    .cand_value (rd_data[EW-1:PRIO_WIDTH]),
    .cand_prio  (rd_data[PRIO_WIDTH-1:0]),
    .best_idx   (best_idx),
    .best_value (best_value),
    .best_prio  (best_prio)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      ptr    <= '0;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      done   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.func == FUNC_INSERT) begin
              done <= 1'b1;
              if (count < CW'(DEPTH)) begin
                count <= count + 1'b1;
              end
            end else if (count == '0) begin
              done <= 1'b1;
            end else begin
              ptr   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            ptr <= ptr + 1'b1;
          end else if (drained) begin
            // minimum is final; entries above it move down next
            ptr   <= CW'(best_idx) + 1'b1;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (rd_en) begin
            ptr <= ptr + 1'b1;
          end else if (drained) begin
            count <= count - 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result word, held until overwritten
  always_ff @(posedge clk) begin
    if (accept) begin
      result.removed_value <= '0;
      result.removed_prio  <= '0;
      result.fill_count    <= 8'(count);
      if (cmd.func == FUNC_INSERT) begin
        if (count < CW'(DEPTH)) begin
          result.status     <= ST_OK;
          result.fill_count <= 8'(count + 1'b1);
        end else begin
          result.status <= ST_FULL;
        end
      end else begin
        result.status <= ST_EMPTY;
      end
    end else if (state == S_SHIFT && !rd_en && drained) begin
      result.status        <= ST_OK;
      result.removed_value <= 32'(best_value);
      result.removed_prio  <= 32'(best_prio);
      result.fill_count    <= 8'(count - 1'b1);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above DEPTH");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while sequencer busy");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> count == CW'(DEPTH))
    else $error("full reported with room left");

  a_shift_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !rd_en && drained) |=> state == S_SHIFT && ptr > CW'(best_idx))
    else $error("shift does not start above the minimum");
`endif

endmodule

`default_nettype wire
